[design/tlvsd_pkg.sv]
// ----------------------------------------------------------------------------
// tlvsd_pkg
// Types and codes shared by the TLV stream decoder.
// ----------------------------------------------------------------------------
package tlvsd_pkg;

  localparam int unsigned ID_W     = 16;
  localparam int unsigned LEN_W    = 24;
  localparam int unsigned BYTE_W   = 8;
  localparam int unsigned TYPE_W   = 2;
  localparam int unsigned KIND_W   = 2;
  localparam int unsigned IN_W     = 8;
  // item_type, item_id, item_length, value_byte, padded to whole bytes
  localparam int unsigned OUT_W    = 56;

  // Type byte fields
  localparam int unsigned EXT_ID_BIT  = 5;
  localparam int unsigned LEN_SEL_LSB = 3;

  // One-hot decoder phase
  typedef enum logic [3:0] {
    PH_TYPE  = 4'b0001,
    PH_ID    = 4'b0010,
    PH_LEN   = 4'b0100,
    PH_VALUE = 4'b1000
  } phase_t;

  // Result kind carried on tuser
  typedef enum logic [KIND_W-1:0] {
    KIND_HEADER = 2'd0,
    KIND_VALUE  = 2'd1,
    KIND_TRUNC  = 2'd2
  } kind_t;

endpackage

[design/tlv_stream_decoder.sv]
// ----------------------------------------------------------------------------
// tlv_stream_decoder
// Decodes back-to-back LwM2M TLV items from a byte stream.
// ----------------------------------------------------------------------------
// Takes one buffer byte per transfer and accepts a byte on every clock while
// the result register is empty or being drained; the single result register
// sits between the header/value parser and the output.
// Header bytes (type, 8 or 16 bit identifier, 0 to 3 length bytes) produce
// no result until the header completes, then one header result; each value
// byte is passed through, the final one flagged on tlast. A buffer that ends
// (input tlast) inside an item gives one truncation result and the parser
// returns to waiting for a type byte. Each result is registered before output.
module tlv_stream_decoder (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         s_axis_tvalid,
  output logic                         s_axis_tready,
  // [7:0] data_byte
  input  logic [tlvsd_pkg::IN_W-1:0]   s_axis_tdata,
  input  logic                         s_axis_tlast,   // buffer_end
  output logic                         m_axis_tvalid,
  input  logic                         m_axis_tready,
  // [1:0] item_type, [17:2] item_id, [41:18] item_length,
  // [49:42] value_byte, [55:50] zero
  output logic [tlvsd_pkg::OUT_W-1:0]  m_axis_tdata,
  // [1:0] kind
  output logic [tlvsd_pkg::KIND_W-1:0] m_axis_tuser,
  output logic                         m_axis_tlast    // last_of_item
);
  import tlvsd_pkg::*;

  // Parser state
  phase_t             phase, phase_next;
  logic [TYPE_W-1:0]  type_held, type_held_next;
  logic [1:0]         id_bytes_left, id_bytes_left_next;
  logic [1:0]         length_bytes_left, length_bytes_left_next;
  logic [2:0]         inline_length, inline_length_next;
  logic [ID_W-1:0]    id_acc, id_acc_next;
  logic [LEN_W-1:0]   len_acc, len_acc_next;
  logic [LEN_W-1:0]   value_bytes_left, value_bytes_left_next;

  // Result register
  logic               res_valid;
  kind_t              res_kind;
  logic [TYPE_W-1:0]  res_type;
  logic [ID_W-1:0]    res_id;
  logic [LEN_W-1:0]   res_len;
  logic [BYTE_W-1:0]  res_byte;
  logic               res_last;

  logic               emit;
  kind_t              emit_kind;
  logic [BYTE_W-1:0]  emit_byte;
  logic               emit_last;
  logic               hdr_done;
  logic               trunc;

  logic               in_fire;
  logic [BYTE_W-1:0]  b;
  logic               buf_end;

  assign s_axis_tready = !res_valid || m_axis_tready;
  assign in_fire       = s_axis_tvalid && s_axis_tready;
  assign b             = s_axis_tdata[BYTE_W-1:0];
  assign buf_end       = s_axis_tlast;

  always_comb begin
    phase_next             = phase;
    type_held_next         = type_held;
    id_bytes_left_next     = id_bytes_left;
    length_bytes_left_next = length_bytes_left;
    inline_length_next     = inline_length;
    id_acc_next            = id_acc;
    len_acc_next           = len_acc;
    value_bytes_left_next  = value_bytes_left;
    emit      = 1'b0;
    emit_kind = KIND_HEADER;
    emit_byte = '0;
    emit_last = 1'b0;
    hdr_done  = 1'b0;
    trunc     = 1'b0;

    unique case (phase)
      PH_ID: begin
        id_acc_next        = {id_acc[ID_W-BYTE_W-1:0], b};
        id_bytes_left_next = id_bytes_left - 2'd1;
        if (id_bytes_left_next != 2'd0) begin
          trunc = buf_end;
        end else if (length_bytes_left == 2'd0) begin
          len_acc_next = {{(LEN_W-3){1'b0}}, inline_length};
          hdr_done     = 1'b1;
        end else begin
          phase_next = PH_LEN;
          trunc      = buf_end;
        end
      end
      PH_LEN: begin
        len_acc_next           = {len_acc[LEN_W-BYTE_W-1:0], b};
        length_bytes_left_next = length_bytes_left - 2'd1;
        if (length_bytes_left_next != 2'd0) begin
          trunc = buf_end;
        end else begin
          hdr_done = 1'b1;
        end
      end
      PH_VALUE: begin
        if (value_bytes_left <= LEN_W'(1)) begin
          emit                  = 1'b1;
          emit_kind             = KIND_VALUE;
          emit_byte             = b;
          emit_last             = 1'b1;
          value_bytes_left_next = '0;
          phase_next            = PH_TYPE;
        end else if (buf_end) begin
          trunc = 1'b1;
        end else begin
          value_bytes_left_next = value_bytes_left - LEN_W'(1);
          emit                  = 1'b1;
          emit_kind             = KIND_VALUE;
          emit_byte             = b;
        end
      end
      default: begin
        // Type byte; unknown phase codes land here too
        type_held_next         = b[7:6];
        id_bytes_left_next     = b[EXT_ID_BIT] ? 2'd2 : 2'd1;
        length_bytes_left_next = b[LEN_SEL_LSB+1:LEN_SEL_LSB];
        inline_length_next     = b[2:0];
        id_acc_next            = '0;
        len_acc_next           = '0;
        value_bytes_left_next  = '0;
        phase_next             = PH_ID;
        trunc                  = buf_end;
      end
    endcase

    if (hdr_done) begin
      if (len_acc_next == '0) begin
        emit       = 1'b1;
        emit_kind  = KIND_HEADER;
        emit_last  = 1'b1;
        phase_next = PH_TYPE;
      end else if (buf_end) begin
        trunc = 1'b1;
      end else begin
        value_bytes_left_next = len_acc_next;
        phase_next            = PH_VALUE;
        emit                  = 1'b1;
        emit_kind             = KIND_HEADER;
      end
    end

    // Buffer ended mid-item: replace any result with the error
    if (trunc) begin
      emit                  = 1'b1;
      emit_kind             = KIND_TRUNC;
      emit_byte             = '0;
      emit_last             = 1'b1;
      phase_next            = PH_TYPE;
      value_bytes_left_next = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase             <= PH_TYPE;
      type_held         <= '0;
      id_bytes_left     <= '0;
      length_bytes_left <= '0;
      inline_length     <= '0;
      id_acc            <= '0;
      len_acc           <= '0;
      value_bytes_left  <= '0;
    end else if (in_fire) begin
      phase             <= phase_next;
      type_held         <= type_held_next;
      id_bytes_left     <= id_bytes_left_next;
      length_bytes_left <= length_bytes_left_next;
      inline_length     <= inline_length_next;
      id_acc            <= id_acc_next;
      len_acc           <= len_acc_next;
      value_bytes_left  <= value_bytes_left_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      res_valid <= 1'b0;
    end else if (s_axis_tready) begin
      res_valid <= in_fire && emit;
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire && emit) begin
      res_kind <= emit_kind;
      res_type <= type_held_next;
      res_id   <= id_acc_next;
      res_len  <= len_acc_next;
      res_byte <= emit_byte;
      res_last <= emit_last;
    end
  end

  assign m_axis_tvalid = res_valid;
  assign m_axis_tuser  = res_kind;
  assign m_axis_tlast  = res_last;
  assign m_axis_tdata  = {{(OUT_W-TYPE_W-ID_W-LEN_W-BYTE_W){1'b0}},
                          res_byte, res_len, res_id, res_type};

  // A truncation result always closes its item
  assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && res_kind == KIND_TRUNC |-> res_last)
    else $error("truncation result without last flag");

  // A zero-length header closes its item
  assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && res_kind == KIND_HEADER && res_len == '0 |-> res_last)
    else $error("zero-length header without last flag");

  // The end of a buffer always returns the parser to the type byte
  assert property (@(posedge clk) disable iff (rst)
    in_fire && buf_end |=> phase == PH_TYPE)
    else $error("parser not at type byte after buffer end");

  // The final value byte returns the parser to the type byte
  assert property (@(posedge clk) disable iff (rst)
    in_fire && phase == PH_VALUE && value_bytes_left <= LEN_W'(1) |=> phase == PH_TYPE)
    else $error("parser not at type byte after last value byte");

  // Input stalls only behind a held result
  assert property (@(posedge clk) disable iff (rst)
    !s_axis_tready |-> m_axis_tvalid && !m_axis_tready)
    else $error("input stalled with result register free");

endmodule

[tb/sv/tb_tlv_stream_decoder.sv]
// ----------------------------------------------------------------------------
// tb_tlv_stream_decoder
// Self-checking testbench for the TLV stream decoder.
// ----------------------------------------------------------------------------
// Bytes go in on the slave stream and are decoded again inside the bench by a
// software copy of the parser. Each expected header, value or truncation
// result is queued, and every result transfer on the master stream is
// compared field by field with the oldest one. The directed tests cover the
// header forms and every point at which a buffer can be cut short. A
// back-pressure test holds the output off long enough to stall the input.
// Random buffers of well-formed items, cut items, oversized items and raw
// noise follow. The sender idles in bursts and the receiver stalls in short
// random runs.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tb_tlv_stream_decoder;
  import tlvsd_pkg::*;

  typedef logic [7:0] byte_q_t[$];

  typedef struct {
    kind_t       kind;
    logic [1:0]  itype;
    logic [15:0] id;
    logic [23:0] len;
    logic [7:0]  vbyte;
    logic        last;
  } tlv_result_t;

  logic                clk = 1'b0;
  logic                rst = 1'b1;
  logic                s_axis_tvalid = 1'b0;
  logic                s_axis_tready;
  // [7:0] data_byte
  logic [IN_W-1:0]     s_axis_tdata = '0;
  logic                s_axis_tlast = 1'b0;   // buffer_end
  logic                m_axis_tvalid;
  logic                m_axis_tready = 1'b0;
  // [1:0] item_type, [17:2] item_id, [41:18] item_length,
  // [49:42] value_byte, [55:50] zero
  logic [OUT_W-1:0]    m_axis_tdata;
  // [1:0] kind
  logic [KIND_W-1:0]   m_axis_tuser;
  logic                m_axis_tlast;          // last_of_item

  tlv_stream_decoder uut (
    .clk           (clk),
    .rst           (rst),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tlast  (s_axis_tlast),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser),
    .m_axis_tlast  (m_axis_tlast)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Parser state mirrored in the bench
  phase_t      dec_phase;
  logic [1:0]  dec_type;
  logic [1:0]  id_left;
  logic [1:0]  lenf_left;
  logic [2:0]  dec_inline;
  logic [15:0] id_acc;
  logic [23:0] len_acc;
  logic [23:0] val_left;

  tlv_result_t want_results[$];
  int unsigned mismatches = 0;
  int unsigned bytes_sent = 0;

  // Flow control knobs
  bit          tx_eager = 1'b1;
  bit          rx_eager = 1'b1;
  int unsigned burst_left = 0;
  int unsigned hold_req = 0;
  int unsigned hold_left = 0;
  int unsigned stall_run = 0;

  function automatic tlv_result_t make_result(kind_t k, logic [7:0] v, logic l);
    tlv_result_t r;
    r.kind  = k;
    r.itype = dec_type;
    r.id    = id_acc;
    r.len   = len_acc;
    r.vbyte = v;
    r.last  = l;
    return r;
  endfunction

  // Advance the parser by one byte; return 1 when a result comes out.
  function automatic bit decode_byte(input logic [7:0] b, input logic fin,
                                     output tlv_result_t r);
    bit hdr_done;
    bit cut;
    hdr_done = 1'b0;
    cut = 1'b0;
    case (dec_phase)
      PH_ID: begin
        id_acc  = {id_acc[7:0], b};
        id_left = id_left - 2'd1;
        if (id_left != 0) begin
          cut = fin;
        end else if (lenf_left == 0) begin
          len_acc  = {21'd0, dec_inline};
          hdr_done = 1'b1;
        end else begin
          dec_phase = PH_LEN;
          cut = fin;
        end
      end
      PH_LEN: begin
        len_acc   = {len_acc[15:0], b};
        lenf_left = lenf_left - 2'd1;
        if (lenf_left != 0) cut = fin;
        else hdr_done = 1'b1;
      end
      PH_VALUE: begin
        if (val_left <= 24'd1) begin
          r = make_result(KIND_VALUE, b, 1'b1);
          val_left  = '0;
          dec_phase = PH_TYPE;
          return 1'b1;
        end
        if (!fin) begin
          val_left = val_left - 24'd1;
          r = make_result(KIND_VALUE, b, 1'b0);
          return 1'b1;
        end
        cut = 1'b1;
      end
      default: begin
        dec_type   = b[7:6];
        id_left    = b[EXT_ID_BIT] ? 2'd2 : 2'd1;
        lenf_left  = b[LEN_SEL_LSB +: 2];
        dec_inline = b[2:0];
        id_acc     = '0;
        len_acc    = '0;
        val_left   = '0;
        dec_phase  = PH_ID;
        cut = fin;
      end
    endcase
    if (hdr_done) begin
      if (len_acc == 0) begin
        r = make_result(KIND_HEADER, 8'd0, 1'b1);
        dec_phase = PH_TYPE;
        return 1'b1;
      end
      if (!fin) begin
        val_left  = len_acc;
        dec_phase = PH_VALUE;
        r = make_result(KIND_HEADER, 8'd0, 1'b0);
        return 1'b1;
      end
      cut = 1'b1;
    end
    if (cut) begin
      r = make_result(KIND_TRUNC, 8'd0, 1'b1);
      dec_phase = PH_TYPE;
      val_left  = '0;
      return 1'b1;
    end
    return 1'b0;
  endfunction

  function automatic void check_field(string name, logic [31:0] want, logic [31:0] got);
    if (got !== want) begin
      $error("%s: expected 0x%0h, got 0x%0h", name, want, got);
      mismatches++;
    end
  endfunction

  // Check result transfers first, then predict from the input transfer.
  always @(posedge clk) begin
    tlv_result_t got;
    tlv_result_t want;
    if (rst) begin
      dec_phase  = PH_TYPE;
      dec_type   = '0;
      id_left    = '0;
      lenf_left  = '0;
      dec_inline = '0;
      id_acc     = '0;
      len_acc    = '0;
      val_left   = '0;
    end else begin
      if (m_axis_tvalid && m_axis_tready) begin
        if (want_results.size() == 0) begin
          $error("result with nothing expected: kind %0d data 0x%0h",
                 m_axis_tuser, m_axis_tdata);
          mismatches++;
        end else begin
          want = want_results.pop_front();
          check_field("kind", 32'(want.kind), 32'(m_axis_tuser));
          check_field("item_type", 32'(want.itype), 32'(m_axis_tdata[1:0]));
          check_field("item_id", 32'(want.id), 32'(m_axis_tdata[17:2]));
          check_field("item_length", 32'(want.len), 32'(m_axis_tdata[41:18]));
          check_field("value_byte", 32'(want.vbyte), 32'(m_axis_tdata[49:42]));
          check_field("last_of_item", 32'(want.last), 32'(m_axis_tlast));
        end
      end
      if (s_axis_tvalid && s_axis_tready) begin
        if (decode_byte(s_axis_tdata, s_axis_tlast, got)) want_results.push_back(got);
      end
    end
  end

  // Receiver: random short stall runs, plus a long hold-off on request.
  always @(posedge clk) begin
    if (hold_req != 0) begin
      hold_left = hold_req;
      hold_req  = 0;
    end
    if (hold_left != 0) begin
      hold_left--;
      m_axis_tready <= 1'b0;
    end else if (stall_run != 0) begin
      stall_run--;
      m_axis_tready <= 1'b0;
    end else if (!rx_eager && $urandom_range(0, 5) == 0) begin
      stall_run = $urandom_range(0, 7);
      m_axis_tready <= 1'b0;
    end else begin
      m_axis_tready <= 1'b1;
    end
  end

  task automatic send_byte(input logic [7:0] b, input logic fin);
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= b;
    s_axis_tlast  <= fin;
    @(posedge clk);
    while (!s_axis_tready) @(posedge clk);
    bytes_sent++;
    if (!tx_eager) begin
      if (burst_left == 0) begin
        s_axis_tvalid <= 1'b0;
        repeat ($urandom_range(1, 5)) @(posedge clk);
        burst_left = $urandom_range(0, 24);
      end else begin
        burst_left--;
      end
    end
  endtask

  // Send bytes 0..end_idx, flagging the buffer end on byte end_idx.
  task automatic send_buffer(input byte_q_t q, input int unsigned end_idx);
    for (int unsigned i = 0; i <= end_idx; i++) send_byte(q[i], i == end_idx);
  endtask

  // Append one item; value bytes stop at 64, and capped says some were left out.
  function automatic void add_item(ref byte_q_t q, input logic [1:0] typ,
                                   input logic long_id, input logic [15:0] id,
                                   input logic [1:0] lw, input logic [2:0] inl,
                                   input logic [23:0] len, output bit capped);
    int unsigned vlen;
    q.push_back({typ, long_id, lw, inl});
    if (long_id) q.push_back(id[15:8]);
    q.push_back(id[7:0]);
    for (int i = lw; i > 0; i--) q.push_back(len[8*i-1 -: 8]);
    vlen   = (lw == 0) ? 32'(inl) : 32'(len);
    capped = vlen > 64;
    if (capped) vlen = 64;
    repeat (vlen) q.push_back(8'($urandom_range(0, 255)));
  endfunction

  task automatic test_header_forms();
    byte_q_t q;
    // full-width id and length field; inline bits ignored; ends on last value
    q = {8'hFF, 8'hFF, 8'hFF, 8'h00, 8'h00, 8'h02, 8'hFF, 8'h00};
    send_buffer(q, q.size() - 1);
    // zero-length item ending the buffer on its header
    q = {8'h00, 8'h00};
    send_buffer(q, q.size() - 1);
  endtask

  task automatic test_truncation();
    byte_q_t q;
    tx_eager = 1'b0;
    rx_eager = 1'b0;
    // cut on the type byte
    q = {8'h40};
    send_buffer(q, 0);
    // cut on the byte that completes a nonzero-length header
    q = {8'h85, 8'h5A};
    send_buffer(q, 1);
    // cut inside a 16-bit id
    q = {8'h20, 8'h12};
    send_buffer(q, 1);
    // cut after the id with the length field still pending
    q = {8'h08, 8'h09};
    send_buffer(q, 1);
    // cut inside a two-byte length field
    q = {8'h10, 8'h01, 8'hFF};
    send_buffer(q, 2);
    // cut as the largest length completes
    q = {8'h18, 8'h77, 8'hFF, 8'hFF, 8'hFF};
    send_buffer(q, 4);
    // cut on a value byte that is not the last
    q = {8'h48, 8'h33, 8'h03, 8'hAA, 8'h55};
    send_buffer(q, 4);
  endtask

  task automatic test_backpressure();
    byte_q_t q;
    bit capped;
    tx_eager = 1'b1;
    rx_eager = 1'b1;
    repeat (4) add_item(q, 2'd1, 1'b0, 16'($urandom_range(0, 255)), 2'd1, 3'd0, 24'd8,
                        capped);
    hold_req = 80;
    send_buffer(q, q.size() - 1);
  endtask

  task automatic send_random_buffer();
    byte_q_t q;
    int unsigned mode;
    int unsigned nitems;
    int unsigned end_idx;
    bit capped;
    logic [1:0] lw;
    logic [23:0] len;
    mode   = $urandom_range(0, 99);
    capped = 1'b0;
    if (mode < 12) begin
      repeat ($urandom_range(1, 10)) q.push_back(8'($urandom_range(0, 255)));
      end_idx = q.size() - 1;
    end else begin
      nitems = $urandom_range(1, 4);
      for (int unsigned k = 0; k < nitems; k++) begin
        lw = 2'($urandom_range(0, 3));
        // an oversized item closes the buffer and gets cut inside its value
        if (mode < 22 && k == nitems - 1) len = 24'($urandom() >> (32 - 8 * lw));
        else len = 24'($urandom_range(0, 10));
        add_item(q, 2'($urandom_range(0, 3)), 1'($urandom_range(0, 1)),
                 16'($urandom_range(0, 65535)), lw, 3'($urandom_range(0, 7)), len,
                 capped);
      end
      if (mode < 35 && !capped) end_idx = $urandom_range(0, q.size() - 1);
      else end_idx = q.size() - 1;
    end
    send_buffer(q, end_idx);
  endtask

  task automatic test_random_buffers();
    while (bytes_sent < 850) begin
      if ($urandom_range(0, 7) == 0) begin
        tx_eager = $urandom_range(0, 2) == 0;
        rx_eager = $urandom_range(0, 2) == 0;
      end
      send_random_buffer();
    end
    s_axis_tvalid <= 1'b0;
  endtask

  initial begin
    repeat (5) @(posedge clk);
    rst <= 1'b0;
    test_header_forms();
    test_truncation();
    test_backpressure();
    test_random_buffers();
    for (int i = 0; i < 20000 && want_results.size() != 0; i++) @(posedge clk);
    repeat (8) @(posedge clk);
    if (want_results.size() != 0) begin
      $error("%0d expected results never arrived", want_results.size());
      mismatches++;
    end
    if (mismatches == 0) begin
      $display("end of test: clean");
    end else begin
      $display("end of test: mismatches");
    end
    $finish;
  end

  initial begin
    #3_000_000;
    $display("end of test: mismatches");
    $finish;
  end

endmodule

[files.f]
design/tlvsd_pkg.sv
design/tlv_stream_decoder.sv
tb/sv/tb_tlv_stream_decoder.sv
